// ===== rtl/core/fq_pkg.sv =====
// shared types and constants for the 17.14 fixed-point alu
// no dependencies
package fq_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int DATA_W        = 32;
   // dividend magnitude is |a| shifted up by the fraction bits
   localparam int QUO_W         = DATA_W + FRACTION_BITS;
   localparam int DIV_STAGES    = QUO_W;
   // prep, multiply, divider steps, finish
   localparam int NUM_STAGES    = DIV_STAGES + 3;

   typedef enum logic [3:0] {
      CMD_TOFIXED = 4'd0,
      CMD_TRUNC   = 4'd1,
      CMD_ROUND   = 4'd2,
      CMD_ADD     = 4'd3,
      CMD_ADDINT  = 4'd4,
      CMD_SUB     = 4'd5,
      CMD_SUBINT  = 4'd6,
      CMD_MUL     = 4'd7,
      CMD_MULINT  = 4'd8,
      CMD_DIV     = 4'd9,
      CMD_DIVINT  = 4'd10
   } command_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [DATA_W-1:0]         res;
      status_type                st;
      logic                      neg;
      logic signed [DATA_W-1:0]  opa;
      logic signed [DATA_W-1:0]  opy;
      logic signed [2*DATA_W-1:0] prod;
      logic [DATA_W-1:0]         dvs;
      logic [DATA_W-1:0]         rem;
      logic [QUO_W-1:0]          quo;
   } stage_type;

endpackage

// ===== rtl/core/fq_prep.sv =====
// first stage: command decode, int operand conversion, add/sub/convert results
// depends on fq_pkg
module fq_prep import fq_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [3:0]               command,
   input  logic signed [DATA_W-1:0] operand_a,
   input  logic signed [DATA_W-1:0] operand_b,
   output stage_type                stage_ff
);

   localparam logic [DATA_W:0] HALF = (DATA_W+1)'(1) << (FRACTION_BITS - 1);

   stage_type         stage_in;
   command_type       cmd;
   logic              int_cmd;
   logic              a_fits;
   logic              b_fits;
   logic [DATA_W-1:0] y;
   status_type        pre_st;
   logic [DATA_W:0]   a_ext;
   logic [DATA_W:0]   a_mag;
   logic [DATA_W:0]   a_rnd;
   logic [DATA_W:0]   tq;
   logic [DATA_W:0]   rq;
   logic [DATA_W:0]   sum;
   logic [DATA_W:0]   dif;
   logic              sum_ovf;
   logic              dif_ovf;

   always_comb begin
      cmd     = command_type'(command);
      int_cmd = (cmd == CMD_ADDINT) || (cmd == CMD_SUBINT) ||
                (cmd == CMD_MULINT) || (cmd == CMD_DIVINT);
      // fits when the top bits are a pure sign extension
      a_fits  = (&operand_a[DATA_W-1 -: FRACTION_BITS+1]) ||
                (~|operand_a[DATA_W-1 -: FRACTION_BITS+1]);
      b_fits  = (&operand_b[DATA_W-1 -: FRACTION_BITS+1]) ||
                (~|operand_b[DATA_W-1 -: FRACTION_BITS+1]);
      if (int_cmd) begin
         y = b_fits ? (operand_b <<< FRACTION_BITS) : '0;
      end else begin
         y = operand_b;
      end
      pre_st = (int_cmd && !b_fits && cmd != CMD_DIVINT) ? ST_OVF : ST_OK;

      a_ext = {operand_a[DATA_W-1], operand_a};
      a_mag = operand_a[DATA_W-1] ? -a_ext : a_ext;
      tq    = a_mag >> FRACTION_BITS;
      a_rnd = a_mag + HALF;
      rq    = a_rnd >> FRACTION_BITS;
      sum   = a_ext + {y[DATA_W-1], y};
      dif   = a_ext - {y[DATA_W-1], y};
      sum_ovf = sum[DATA_W] ^ sum[DATA_W-1];
      dif_ovf = dif[DATA_W] ^ dif[DATA_W-1];

      stage_in      = '0;
      stage_in.kind = KIND_DIRECT;
      stage_in.st   = ST_OK;
      stage_in.opa  = operand_a;
      stage_in.opy  = y;
      stage_in.neg  = operand_a[DATA_W-1] ^ y[DATA_W-1];
      stage_in.dvs  = y[DATA_W-1] ? -y : y;
      stage_in.quo  = {a_mag[DATA_W-1:0], {FRACTION_BITS{1'b0}}};

      unique case (cmd) inside
         CMD_TOFIXED: begin
            stage_in.res = a_fits ? DATA_W'(operand_a <<< FRACTION_BITS) : '0;
            stage_in.st  = a_fits ? ST_OK : ST_OVF;
         end
         CMD_TRUNC: begin
            stage_in.res = operand_a[DATA_W-1] ? DATA_W'(-tq) : tq[DATA_W-1:0];
         end
         CMD_ROUND: begin
            stage_in.res = operand_a[DATA_W-1] ? DATA_W'(-rq) : rq[DATA_W-1:0];
         end
         CMD_ADD, CMD_ADDINT: begin
            stage_in.res = sum_ovf ? '0 : sum[DATA_W-1:0];
            stage_in.st  = sum_ovf ? ST_OVF : pre_st;
         end
         CMD_SUB, CMD_SUBINT: begin
            stage_in.res = dif_ovf ? '0 : dif[DATA_W-1:0];
            stage_in.st  = dif_ovf ? ST_OVF : pre_st;
         end
         CMD_MUL, CMD_MULINT: begin
            stage_in.kind = KIND_MUL;
            stage_in.st   = pre_st;
         end
         CMD_DIV, CMD_DIVINT: begin
            if (y == '0) begin
               stage_in.st = ST_DIV0;
            end else begin
               stage_in.kind = KIND_DIV;
            end
         end
         default: begin
            stage_in.res = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== rtl/core/fq_mul_stage.sv =====
// second stage: full 32x32 signed product
// depends on fq_pkg
module fq_mul_stage import fq_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  stage_type stage_in,
   output stage_type stage_ff
);

   stage_type nxt_in;

   always_comb begin
      nxt_in      = stage_in;
      nxt_in.prod = stage_in.opa * stage_in.opy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= nxt_in;
      end
   end

endmodule

// ===== rtl/core/fq_div_stage.sv =====
// one restoring division step: one quotient bit per stage
// depends on fq_pkg
module fq_div_stage import fq_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  stage_type stage_in,
   output stage_type stage_ff
);

   stage_type     nxt_in;
   logic [DATA_W:0] trial;
   logic          take;

   always_comb begin
      trial  = {stage_in.rem, stage_in.quo[QUO_W-1]};
      take   = trial >= {1'b0, stage_in.dvs};
      nxt_in = stage_in;
      nxt_in.rem = take ? DATA_W'(trial - {1'b0, stage_in.dvs}) : trial[DATA_W-1:0];
      nxt_in.quo = {stage_in.quo[QUO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= nxt_in;
      end
   end

endmodule

// ===== rtl/core/fq_finish.sv =====
// last stage: product scaling, quotient sign, overflow, output register
// depends on fq_pkg
module fq_finish import fq_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  stage_type         stage_in,
   output logic [DATA_W-1:0] result_ff,
   output logic [1:0]        status_ff
);

   logic signed [2*DATA_W-1:0] bias;
   logic signed [2*DATA_W-1:0] scaled;
   logic                       mul_ovf;
   logic [QUO_W:0]             qs;
   logic                       div_ovf;
   logic [DATA_W-1:0]          result_in;
   status_type                 status_in;

   always_comb begin
      // truncate toward zero when dropping the fraction
      bias    = stage_in.prod[2*DATA_W-1] ?
                (2*DATA_W)'((64'(1) << FRACTION_BITS) - 1) : '0;
      scaled  = (stage_in.prod + bias) >>> FRACTION_BITS;
      mul_ovf = !((&scaled[2*DATA_W-1:DATA_W-1]) || (~|scaled[2*DATA_W-1:DATA_W-1]));
      qs      = stage_in.neg ? -{1'b0, stage_in.quo} : {1'b0, stage_in.quo};
      div_ovf = !((&qs[QUO_W:DATA_W-1]) || (~|qs[QUO_W:DATA_W-1]));

      case (stage_in.kind)
         KIND_MUL: begin
            result_in = scaled[DATA_W-1:0];
            status_in = mul_ovf ? ST_OVF : stage_in.st;
         end
         KIND_DIV: begin
            result_in = qs[DATA_W-1:0];
            status_in = div_ovf ? ST_OVF : stage_in.st;
         end
         default: begin
            result_in = stage_in.res;
            status_in = stage_in.st;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== rtl/core/fixed_point_q17_14_alu.sv =====
// signed 17.14 fixed-point alu, top level
// depends on fq_pkg, fq_prep, fq_mul_stage, fq_div_stage, fq_finish
//
// one transaction on req_ gives exactly one transaction on rsp_, in order.
// the block takes a new transaction every cycle unless the pipe is full
// and rsp_ready is low. stages: decode, multiply, 46 divider stages that
// resolve one quotient bit each, and a finish stage that drives the output
// registers. each stage has its own valid bit and loads whenever it is
// empty or the stage after it moves, so bubbles collapse and a stalled
// rsp_ side still lets transactions in until the pipe is full. status: 0
// ok, 1 overflow, 2 divide by zero; add, sub and int conversion return 0
// on result overflow, a bad int operand counts as 0, multiply and divide
// return the low 32 bits with overflow flagged.
module fixed_point_q17_14_alu import fq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [3:0]               req_command,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic [1:0]               rsp_status
);

   // per-stage valid bits and load enables
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   en;
   stage_type             pipe [NUM_STAGES-1];
   logic [DATA_W-1:0]     result_q;

   // a stage loads when empty or when its successor advances
   assign en[NUM_STAGES] = rsp_ready;
   genvar gi;
   generate
      for (gi = 0; gi < NUM_STAGES; gi++) begin : g_en
         assign en[gi] = !vld_ff[gi] || en[gi+1];
      end
   endgenerate

   always_comb begin
      vld_in = vld_ff;
      if (en[0]) begin
         vld_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // decode, conversion, direct results
   fq_prep u_prep (
      .clock     (clock),
      .en        (en[0]),
      .command   (req_command),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .stage_ff  (pipe[0])
   );

   // full product
   fq_mul_stage u_mul (
      .clock    (clock),
      .en       (en[1]),
      .stage_in (pipe[0]),
      .stage_ff (pipe[1])
   );

   // divider chain
   generate
      for (gi = 0; gi < DIV_STAGES; gi++) begin : g_div
         fq_div_stage u_div (
            .clock    (clock),
            .en       (en[gi+2]),
            .stage_in (pipe[gi+1]),
            .stage_ff (pipe[gi+2])
         );
      end
   endgenerate

   // scaling, sign fix, overflow and output registers
   fq_finish u_finish (
      .clock     (clock),
      .en        (en[NUM_STAGES-1]),
      .stage_in  (pipe[NUM_STAGES-2]),
      .result_ff (result_q),
      .status_ff (rsp_status)
   );

   assign req_ready  = en[0];
   assign rsp_valid  = vld_ff[NUM_STAGES-1];
   assign rsp_result = result_q;

`ifndef NO_ASSERTIONS
   // a free output side always lets a new transaction in
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // status code 3 is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_OVF ||
                     rsp_status == ST_DIV0))
      else $error("bad status code");

   // divide by zero always answers zero
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DIV0) |-> (rsp_result == '0))
      else $error("nonzero result on divide by zero");

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("rsp_valid after reset");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench for the 17.14 fixed-point alu: directed and random commands,
// predicted results checked in order; depends on fq_pkg and the alu rtl
`timescale 1ns / 100ps

// holds predicted results of accepted requests and checks responses in order
class alu_scoreboard;
   logic [31:0] exp_result [$];
   logic [1:0]  exp_status [$];
   int          errors;
   int          checked;

   // convert integer to fixed; bad flags out of range
   static function longint to_fixed(input logic signed [31:0] n, output bit bad);
      longint lim;
      lim = longint'(1) << (31 - fq_pkg::FRACTION_BITS);
      bad = !(n < lim && n >= -lim);
      return bad ? 0 : longint'(n) * (longint'(1) << fq_pkg::FRACTION_BITS);
   endfunction

   function void note_request(input logic [3:0] cmd, input logic signed [31:0] a,
                              input logic signed [31:0] b);
      longint q, y, s, h, v;
      logic [31:0] r;
      logic [1:0] st;
      bit bad;
      q = longint'(1) << fq_pkg::FRACTION_BITS;
      y = b;
      st = fq_pkg::ST_OK;
      r = '0;
      bad = 0;
      if (cmd == fq_pkg::CMD_ADDINT || cmd == fq_pkg::CMD_SUBINT ||
          cmd == fq_pkg::CMD_MULINT || cmd == fq_pkg::CMD_DIVINT) begin
         y = to_fixed(b, bad);
         if (bad && cmd != fq_pkg::CMD_DIVINT) st = fq_pkg::ST_OVF;
      end
      case (cmd)
         fq_pkg::CMD_TOFIXED: begin
            s = to_fixed(a, bad);
            if (bad) st = fq_pkg::ST_OVF;
            r = s[31:0];
         end
         fq_pkg::CMD_TRUNC: begin
            s = longint'(a) / q;
            r = s[31:0];
         end
         fq_pkg::CMD_ROUND: begin
            h = q / 2;
            v = (a >= 0) ? (longint'(a) + h) / q : (longint'(a) - h) / q;
            r = v[31:0];
         end
         fq_pkg::CMD_ADD, fq_pkg::CMD_ADDINT, fq_pkg::CMD_SUB, fq_pkg::CMD_SUBINT: begin
            if (cmd == fq_pkg::CMD_ADD || cmd == fq_pkg::CMD_ADDINT) s = longint'(a) + y;
            else s = longint'(a) - y;
            if (s > 64'sd2147483647 || s < -64'sd2147483648) begin
               st = fq_pkg::ST_OVF;
               r = '0;
            end else r = s[31:0];
         end
         fq_pkg::CMD_MUL, fq_pkg::CMD_MULINT: begin
            s = (longint'(a) * y) / q;
            if (s > 64'sd2147483647 || s < -64'sd2147483648) st = fq_pkg::ST_OVF;
            r = s[31:0];
         end
         fq_pkg::CMD_DIV, fq_pkg::CMD_DIVINT: begin
            if (y == 0) begin
               st = fq_pkg::ST_DIV0;
               r = '0;
            end else begin
               s = (longint'(a) * q) / y;
               if (s > 64'sd2147483647 || s < -64'sd2147483648) st = fq_pkg::ST_OVF;
               r = s[31:0];
            end
         end
         default: begin
            r = '0;
            st = fq_pkg::ST_OK;
         end
      endcase
      exp_result.push_back(r);
      exp_status.push_back(st);
   endfunction

   function void check_response(input logic [31:0] r, input logic [1:0] st);
      logic [31:0] er;
      logic [1:0] es;
      if (exp_result.size() == 0) begin
         $display("%0t: unexpected response result %h status %0d", $time, r, st);
         errors++;
         return;
      end
      er = exp_result.pop_front();
      es = exp_status.pop_front();
      checked++;
      if (r !== er) begin
         $display("%0t: result mismatch expected %h actual %h", $time, er, r);
         errors++;
      end
      if (st !== es) begin
         $display("%0t: status mismatch expected %0d actual %0d", $time, es, st);
         errors++;
      end
   endfunction
endclass

module testbench;
   import fq_pkg::*;

   localparam int LATENCY     = NUM_STAGES;
   localparam int RANDOM_REQS = 800;
   localparam int CYCLE_LIMIT = 200000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [3:0]               req_command = '0;
   logic signed [DATA_W-1:0] req_operand_a = '0;
   logic signed [DATA_W-1:0] req_operand_b = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_result;
   logic [1:0]               rsp_status;

   alu_scoreboard board;
   int  cycles = 0;
   bit  calm = 1'b0;      // stretch with no idling on either side
   bit  hold_off = 1'b0;  // long receiver stall to fill the pipe
   int  sent = 0;

   always #5 clock = ~clock;

   fixed_point_q17_14_alu DUT (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_operand_a,
      .req_operand_b, .rsp_valid, .rsp_ready, .rsp_result, .rsp_status
   );

   // cycle counter and timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("fixed_point_q17_14_alu verification failed");
         $finish;
      end
   end

   // note accepted requests and check accepted responses at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_command, req_operand_a, req_operand_b);
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_result, rsp_status);
   end

   // receiver: random stalls, except during calm or while holding off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off) rsp_ready <= 1'b0;
      else if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 37);
   end

   // long hold-off counted here, while the sender keeps offering
   initial begin
      wait (sent >= 300);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (3 * LATENCY) @(negedge clock);
      hold_off = 1'b0;
   end

   // offer one transaction, keeping valid high until accepted
   task automatic send_request(input logic [3:0] cmd, input logic [31:0] a,
                               input logic [31:0] b);
      if (!calm)
         while ($urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // operand with bias toward edges and the convertible integer range
   function automatic logic [31:0] pick_value(input bit as_int);
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'(signed'($urandom_range(8)) - 4);
         3: return 32'(signed'($urandom_range(262143)) - 131072);
         4: return as_int ? 32'(signed'($urandom_range(20)) - 10)
                          : 32'(signed'($urandom_range(8)) - 4) << FRACTION_BITS;
         5: return 32'(signed'($urandom_range(40)) - 20) * 32'd8192;
         6: return $urandom_range(1) ? 32'd131072 : 32'hfffd_ffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic directed_part();
      send_request(CMD_TOFIXED, 32'd131071, 32'd0);
      send_request(CMD_TOFIXED, 32'hfffe_0000, 32'hffff_ffff);   // -131072 fits
      send_request(CMD_TOFIXED, 32'd131072, 32'd0);              // out of range
      send_request(CMD_TOFIXED, 32'hfffd_ffff, 32'd0);
      send_request(CMD_TRUNC, 32'hffff_e000, 32'd0);             // -0.5
      send_request(CMD_ROUND, 32'h0000_2000, 32'd0);             // half up
      send_request(CMD_ROUND, 32'hffff_e000, 32'd0);             // half down
      send_request(CMD_ROUND, 32'h7fff_ffff, 32'd0);
      send_request(CMD_ROUND, 32'h8000_0000, 32'd0);
      send_request(CMD_ADD, 32'h7fff_ffff, 32'd1);               // add overflow
      send_request(CMD_ADD, 32'h8000_0000, 32'hffff_ffff);
      send_request(CMD_ADDINT, 32'd5, 32'd200000);               // bad int operand
      send_request(CMD_ADDINT, 32'h7fff_0000, 32'd1);
      send_request(CMD_SUB, 32'h8000_0000, 32'd1);
      send_request(CMD_SUBINT, 32'd0, 32'hfffe_0000);
      send_request(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);       // multiply overflow
      send_request(CMD_MUL, 32'h8000_0000, 32'hffff_c000);
      send_request(CMD_MULINT, 32'h0001_0000, 32'h8000_0000);
      send_request(CMD_DIV, 32'h1234_5678, 32'd0);               // divide by zero
      send_request(CMD_DIV, 32'h8000_0000, 32'd1);               // divide overflow
      send_request(CMD_DIVINT, 32'd100, 32'd131072);             // bad int divisor
      send_request(CMD_DIVINT, 32'hffff_0000, 32'd3);
      send_request(4'd11, 32'hffff_ffff, 32'hffff_ffff);         // unused commands
      send_request(4'd15, 32'h0, 32'h0);
   endtask

   initial begin
      int c;
      board = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_part();
      for (int i = 0; i < RANDOM_REQS; i++) begin
         calm = (i >= 500 && i < 620);
         c = ($urandom_range(19) == 0) ? $urandom_range(15, 11) : $urandom_range(10);
         send_request(c[3:0], pick_value(c == CMD_TOFIXED), pick_value(c[0] == 1'b0));
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (board.exp_result.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d transactions, checked %0d responses, including a long", sent,
               board.checked);
      $display("output stall, all commands, range edges and unused codes");
      if (board.errors == 0) begin
         $display("fixed_point_q17_14_alu verification clean");
      end else begin
         $display("fixed_point_q17_14_alu verification failed");
      end
      $finish;
   end
endmodule
